>>> hw/rtl/ffa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// First-fit allocator package
// Shared constants, codes and transaction types of the free-list allocator.
// ----------------------------------------------------------------------------
package ffa_pkg;

  localparam int DEPTH = 4096;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  localparam logic [31:0] ROUND_ADD  = 32'h0000_0fff;
  localparam logic [31:0] ROUND_MASK = 32'hffff_f000;

  typedef enum logic {
    CMD_ALLOC = 1'b0,
    CMD_FREE  = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_NOFIT = 2'd1,
    STAT_LOST  = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RD,
    S_CHK,
    S_RES,
    S_SD_RD,
    S_SD_WR,
    S_SU_RD,
    S_SU_WR,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [31:0] start;
    logic [31:0] len;
  } entry_t;

  typedef struct packed {
    cmd_t        cmd;
    logic [31:0] addr;
    logic [31:0] size;
  } req_t;

  typedef struct packed {
    logic [31:0]      addr;
    status_t          status;
    logic [31:0]      total_free;
    logic [CNT_W-1:0] entries_used;
    logic [CNT_W-1:0] peak_entries;
    logic [31:0]      lost_count;
    logic [31:0]      lost_bytes;
  } rsp_t;

endpackage
`default_nettype wire

>>> hw/rtl/ffa_engine.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// First-fit allocator engine
// Holds the sorted region table in one synchronous memory and walks it to
// serve one allocate or free request at a time.
// ----------------------------------------------------------------------------
module ffa_engine (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  ffa_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output ffa_pkg::rsp_t rsp
);

  ffa_pkg::entry_t mem [ffa_pkg::DEPTH];
  ffa_pkg::entry_t mem_rdata;
  ffa_pkg::entry_t mem_wdata;
  logic                      mem_we;
  logic [ffa_pkg::IDX_W-1:0] mem_waddr;
  logic [ffa_pkg::IDX_W-1:0] mem_raddr;

  ffa_pkg::state_t state, state_next;
  logic [ffa_pkg::CNT_W-1:0] k, k_next, j, j_next;
  logic [ffa_pkg::CNT_W-1:0] count, count_next, peak, peak_next;
  logic [ffa_pkg::CNT_W-1:0] k_dec, j_dec;
  ffa_pkg::entry_t cur, cur_next, prev, prev_next;
  logic upv, upv_next;
  ffa_pkg::req_t q, q_next;
  logic [31:0] res_addr, res_addr_next;
  ffa_pkg::status_t res_status, res_status_next;
  logic [31:0] total, total_next, lost_cnt, lost_cnt_next, lost_byt, lost_byt_next;

  logic        hit, lower_ok, upper_ok, room;
  logic [31:0] alen;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    mem_rdata <= mem[mem_raddr];
  end

  assign k_dec    = k - ffa_pkg::CNT_W'(1);
  assign j_dec    = j - ffa_pkg::CNT_W'(1);
  assign hit      = mem_rdata.len >= q.size;
  assign alen     = mem_rdata.len - q.size;
  assign lower_ok = (k != '0) && ((prev.start + prev.len) == q.addr);
  assign upper_ok = upv && ((q.addr + q.size) == cur.start);
  assign room     = count < ffa_pkg::CNT_W'(ffa_pkg::DEPTH);

  always_comb begin
    state_next = state;
    unique case (state)
      ffa_pkg::S_IDLE: if (req_valid) state_next = ffa_pkg::S_RD;
      ffa_pkg::S_RD: begin
        if (k == count) begin
          state_next = (q.cmd == ffa_pkg::CMD_ALLOC) ? ffa_pkg::S_DONE : ffa_pkg::S_RES;
        end else begin
          state_next = ffa_pkg::S_CHK;
        end
      end
      ffa_pkg::S_CHK: begin
        if (q.cmd == ffa_pkg::CMD_ALLOC) begin
          if (hit) begin
            state_next = (alen == '0) ? ffa_pkg::S_SD_RD : ffa_pkg::S_DONE;
          end else begin
            state_next = ffa_pkg::S_RD;
          end
        end else begin
          state_next = (mem_rdata.start > q.addr) ? ffa_pkg::S_RES : ffa_pkg::S_RD;
        end
      end
      ffa_pkg::S_RES: begin
        priority if (lower_ok) state_next = upper_ok ? ffa_pkg::S_SD_RD : ffa_pkg::S_DONE;
        else if (upper_ok) state_next = ffa_pkg::S_DONE;
        else if (room) state_next = ffa_pkg::S_SU_RD;
        else state_next = ffa_pkg::S_DONE;
      end
      ffa_pkg::S_SD_RD: state_next = (j == count) ? ffa_pkg::S_DONE : ffa_pkg::S_SD_WR;
      ffa_pkg::S_SD_WR: state_next = ffa_pkg::S_SD_RD;
      ffa_pkg::S_SU_RD: state_next = (j == k) ? ffa_pkg::S_DONE : ffa_pkg::S_SU_WR;
      ffa_pkg::S_SU_WR: state_next = ffa_pkg::S_SU_RD;
      ffa_pkg::S_DONE:  if (rsp_ready) state_next = ffa_pkg::S_IDLE;
      default:          state_next = ffa_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    mem_we          = 1'b0;
    mem_waddr       = k[ffa_pkg::IDX_W-1:0];
    mem_wdata       = mem_rdata;
    mem_raddr       = k[ffa_pkg::IDX_W-1:0];
    k_next          = k;
    j_next          = j;
    count_next      = count;
    peak_next       = peak;
    cur_next        = cur;
    prev_next       = prev;
    upv_next        = upv;
    q_next          = q;
    res_addr_next   = res_addr;
    res_status_next = res_status;
    total_next      = total;
    lost_cnt_next   = lost_cnt;
    lost_byt_next   = lost_byt;
    unique case (state)
      ffa_pkg::S_IDLE: begin
        if (req_valid) begin
          q_next          = req;
          k_next          = '0;
          res_addr_next   = '0;
          res_status_next = ffa_pkg::STAT_OK;
        end
      end
      ffa_pkg::S_RD: begin
        if (k == count) begin
          upv_next = 1'b0;
          if (q.cmd == ffa_pkg::CMD_ALLOC) res_status_next = ffa_pkg::STAT_NOFIT;
        end
      end
      ffa_pkg::S_CHK: begin
        cur_next = mem_rdata;
        if (q.cmd == ffa_pkg::CMD_ALLOC) begin
          if (hit) begin
            res_addr_next = mem_rdata.start;
            total_next    = total - q.size;
            if (alen == '0) begin
              count_next = count - ffa_pkg::CNT_W'(1);
              j_next     = k;
            end else begin
              mem_we    = 1'b1;
              mem_wdata = '{start: mem_rdata.start + q.size, len: alen};
            end
          end else begin
            k_next = k + ffa_pkg::CNT_W'(1);
          end
        end else if (mem_rdata.start > q.addr) begin
          upv_next = 1'b1;
        end else begin
          prev_next = mem_rdata;
          k_next    = k + ffa_pkg::CNT_W'(1);
        end
      end
      ffa_pkg::S_RES: begin
        priority if (lower_ok) begin
          mem_we     = 1'b1;
          mem_waddr  = k_dec[ffa_pkg::IDX_W-1:0];
          total_next = total + q.size;
          mem_wdata  = '{start: prev.start,
                         len: prev.len + q.size + (upper_ok ? cur.len : 32'd0)};
          if (upper_ok) begin
            count_next = count - ffa_pkg::CNT_W'(1);
            j_next     = k;
          end
        end else if (upper_ok) begin
          mem_we     = 1'b1;
          total_next = total + q.size;
          mem_wdata  = '{start: q.addr, len: cur.len + q.size};
        end else if (room) begin
          j_next = count;
        end else begin
          res_status_next = ffa_pkg::STAT_LOST;
          lost_cnt_next   = lost_cnt + 32'd1;
          lost_byt_next   = lost_byt + q.size;
        end
      end
      ffa_pkg::S_SD_RD: begin
        mem_raddr = j[ffa_pkg::IDX_W-1:0] + ffa_pkg::IDX_W'(1);
      end
      ffa_pkg::S_SD_WR: begin
        mem_we    = 1'b1;
        mem_waddr = j[ffa_pkg::IDX_W-1:0];
        j_next    = j + ffa_pkg::CNT_W'(1);
      end
      ffa_pkg::S_SU_RD: begin
        mem_raddr = j_dec[ffa_pkg::IDX_W-1:0];
        if (j == k) begin
          mem_we     = 1'b1;
          mem_wdata  = '{start: q.addr, len: q.size};
          total_next = total + q.size;
          count_next = count + ffa_pkg::CNT_W'(1);
          if (peak < count + ffa_pkg::CNT_W'(1)) peak_next = count + ffa_pkg::CNT_W'(1);
        end
      end
      ffa_pkg::S_SU_WR: begin
        mem_we    = 1'b1;
        mem_waddr = j[ffa_pkg::IDX_W-1:0];
        j_next    = j_dec;
      end
      ffa_pkg::S_DONE: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ffa_pkg::S_IDLE;
      count    <= '0;
      peak     <= '0;
      total    <= '0;
      lost_cnt <= '0;
      lost_byt <= '0;
    end else begin
      state    <= state_next;
      count    <= count_next;
      peak     <= peak_next;
      total    <= total_next;
      lost_cnt <= lost_cnt_next;
      lost_byt <= lost_byt_next;
    end
  end

  always_ff @(posedge clk) begin
    k          <= k_next;
    j          <= j_next;
    cur        <= cur_next;
    prev       <= prev_next;
    upv        <= upv_next;
    q          <= q_next;
    res_addr   <= res_addr_next;
    res_status <= res_status_next;
  end

  assign req_ready = state == ffa_pkg::S_IDLE;
  assign rsp_valid = state == ffa_pkg::S_DONE;
  assign rsp       = '{addr: res_addr, status: res_status, total_free: total,
                       entries_used: count, peak_entries: peak,
                       lost_count: lost_cnt, lost_bytes: lost_byt};

  a_peak_covers_count: assert property (@(posedge clk) disable iff (rst)
    peak >= count) else $error("peak below entry count");
  a_count_in_range: assert property (@(posedge clk) disable iff (rst)
    count <= ffa_pkg::CNT_W'(ffa_pkg::DEPTH)) else $error("entry count overflow");
  a_shift_up_room: assert property (@(posedge clk) disable iff (rst)
    (state == ffa_pkg::S_SU_RD) |-> room) else $error("insert into full table");
  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready) |=> (state == ffa_pkg::S_RD)) else $error("request not started");

endmodule
`default_nettype wire

>>> hw/rtl/first_fit_free_list_allocator_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// First-fit free-list allocator
// Stream wrapper: size rounding, engine and registered result.
// ----------------------------------------------------------------------------
// The free regions live in one 4096-entry synchronous memory, sorted by
// address, and a single read port walks them entry by entry. A request
// walks the table to find its place, then moves the entries behind it one
// by one when a region is removed or inserted. Memory contents need no
// clearing; only entries below the count are read. One request is handled
// at a time; a finished result waits in the output register while the next
// transaction is accepted.
module first_fit_free_list_allocator_top (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [63:0]  s_axis_tdata,  // region_addr[31:0], region_size[63:32]
  input  logic [1:0]   s_axis_tuser,  // cmd[0], round_4k[1]
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // result_addr[31:0], total_free[63:32], entries_used[76:64],
  // peak_entries[89:77], lost_count[121:90], lost_bytes[153:122], zero pad
  output logic [159:0] m_axis_tdata,
  output logic [1:0]   m_axis_tuser   // status[1:0]
);

  ffa_pkg::req_t req;
  ffa_pkg::rsp_t rsp, out_q;
  logic          rsp_valid, rsp_ready;
  logic [31:0]   size_in;

  assign size_in = s_axis_tdata[63:32];
  assign req.cmd  = ffa_pkg::cmd_t'(s_axis_tuser[0]);
  assign req.addr = s_axis_tdata[31:0];
  assign req.size = s_axis_tuser[1] ? ((size_in + ffa_pkg::ROUND_ADD) & ffa_pkg::ROUND_MASK)
                                    : size_in;

  ffa_engine u_engine (
    .clk       (clk),
    .rst       (rst),
    .req_valid (s_axis_tvalid),
    .req_ready (s_axis_tready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  assign rsp_ready = !m_axis_tvalid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (rsp_ready) begin
      m_axis_tvalid <= rsp_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rsp_ready && rsp_valid) begin
      out_q <= rsp;
    end
  end

  assign m_axis_tdata = {6'd0, out_q.lost_bytes, out_q.lost_count, out_q.peak_entries,
                         out_q.entries_used, out_q.total_free, out_q.addr};
  assign m_axis_tuser = out_q.status;

endmodule
`default_nettype wire
